[rtl/ang_pkg.sv]
// Shared constants and register codes for the audio noise gate.
package ang_pkg;

   localparam int CHANNELS_DEF    = 2;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int CHAN_W     = 1;
   localparam int GAIN_W     = 17;
   localparam int COEF_W     = 16;
   localparam int THR_W      = 24;
   localparam int MUL_B_W    = GAIN_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

   localparam logic [CSR_ADDR_W-1:0] CSR_GATE_ENABLE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_COEFF  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_COEFF = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTH_COEFF  = 3'd4;

   localparam logic [THR_W-1:0]  THRESHOLD_RST = 24'd83886;
   localparam logic [COEF_W-1:0] ATTACK_RST    = 16'd64184;
   localparam logic [COEF_W-1:0] RELEASE_RST   = 16'd65509;
   localparam logic [COEF_W-1:0] SMOOTH_RST    = 16'd64184;

endpackage

[rtl/ang_mul.sv]
// Shared signed multiplier with a registered floor shift right by sixteen.
module ang_mul #(
   parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [SAMPLE_BITS+1:0]        a,
   input  logic signed [ang_pkg::MUL_B_W-1:0]   b,
   output logic signed [SAMPLE_BITS+3:0]        res
);
   import ang_pkg::*;

   localparam int PW = SAMPLE_BITS + 2 + MUL_B_W;

   logic signed [PW-1:0]            prod;
   logic signed [SAMPLE_BITS+3:0]   res_ff;
   logic signed [SAMPLE_BITS+3:0]   res_in;

   assign prod   = a * b;
   assign res_in = prod[PW-1:COEF_W];
   assign res    = res_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule

[rtl/audio_noise_gate.sv]
// Top level of the per-channel audio noise gate with envelope follower and gain smoothing.
//
//   port group   direction   handshake            contents
//   req_         in          req_valid/ready      channel number and signed sample
//   rsp_         out         rsp_valid/ready      gated sample, gain, level, level flag
//   csr_         in          csr_we               register index and write data
//
// Each item steps through env multiply, env add, gain multiply, gain add, output multiply
// and done before its result enters the output register; no new item is accepted until then;
// one shared multiplier does the envelope, the gain and the output products in turn.
// Per-channel state lives in a small synchronous memory with a valid bit per entry;
// reset clears the valid bits at once, so an unwritten channel reads as zero envelope
// and unity gain. A stalled result holds the last stage until the output register frees.
module audio_noise_gate #(
   parameter int CHANNELS    = ang_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ang_pkg::CHAN_W-1:0]          req_channel,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic [ang_pkg::GAIN_W-1:0]          rsp_gate_gain,
   output logic [SAMPLE_BITS-1:0]              rsp_input_level,
   output logic                                rsp_level_valid,
   input  logic                                csr_we,
   input  logic [ang_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ang_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ang_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int AW    = SB + 2;
   localparam int RW    = SB + 4;
   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = (SB > THR_W) ? SB : THR_W;
   localparam int MEM_W = SB + GAIN_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ENV_MUL  = 3'd1;
   localparam logic [2:0] S_ENV_ADD  = 3'd2;
   localparam logic [2:0] S_GAIN_MUL = 3'd3;
   localparam logic [2:0] S_GAIN_ADD = 3'd4;
   localparam logic [2:0] S_OUT_MUL  = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]              state_ff, state_in;

   logic                    enable_ff, enable_in;
   logic [THR_W-1:0]        thr_ff, thr_in;
   logic [COEF_W-1:0]       attack_ff, attack_in;
   logic [COEF_W-1:0]       release_ff, release_in;
   logic [COEF_W-1:0]       smooth_ff, smooth_in;

   logic [MEM_W-1:0]        mem [CHANNELS];
   logic [CHANNELS-1:0]     vld_ff, vld_in;
   logic [MEM_W-1:0]        rd_data_ff;
   logic                    ent_vld_ff;
   logic                    rd_en;
   logic [CH_AW-1:0]        rd_addr;
   logic                    wr_en;

   logic [CH_AW-1:0]        idx_ff, idx_in;
   logic                    oor_ff, oor_in;
   logic                    act_ff, act_in;
   logic                    ch0_ff, ch0_in;
   logic signed [SB-1:0]    samp_ff, samp_in;
   logic [SB-1:0]           level_ff, level_in;
   logic                    atk_ff, atk_in;
   logic                    tgt_ff, tgt_in;
   logic [SB-1:0]           env_ff, env_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]    rsp_sample_ff, rsp_sample_in;
   logic [GAIN_W-1:0]       rsp_gain_ff, rsp_gain_in;
   logic [SB-1:0]           rsp_level_ff, rsp_level_in;
   logic                    rsp_lvl_vld_ff, rsp_lvl_vld_in;

   logic                    accept;
   logic                    load_rsp;
   logic                    req_oor;
   logic [SB-1:0]           req_level;
   logic [SB-1:0]           env_cur;
   logic [GAIN_W-1:0]       gain_rd;
   logic                    tgt_now;
   logic signed [SB:0]      env_diff;
   logic signed [GAIN_W:0]  gain_diff;
   logic [RW-1:0]           env_sum;
   logic [RW-1:0]           gain_sum;
   logic                    mul_en;
   logic signed [AW-1:0]    mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [RW-1:0]    mul_res;

   ang_mul #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .res   (mul_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign req_oor   = (int'(req_channel) >= CHANNELS);
   assign req_level = req_sample_in[SB-1] ? (~req_sample_in + 1'b1) : req_sample_in;
   assign rd_en     = accept;
   assign rd_addr   = req_oor ? '0 : CH_AW'(req_channel);
   assign wr_en     = (state_ff == S_GAIN_ADD) && act_ff;

   assign env_cur   = ent_vld_ff ? rd_data_ff[MEM_W-1:GAIN_W] : '0;
   assign gain_rd   = (ent_vld_ff && !oor_ff) ? rd_data_ff[GAIN_W-1:0] : UNITY_GAIN;
   assign tgt_now   = (CMP_W'(env_ff) > CMP_W'(thr_ff));
   assign env_diff  = {1'b0, env_cur} - {1'b0, level_ff};
   assign gain_diff = {1'b0, gain_ff} - (tgt_now ? {1'b0, UNITY_GAIN} : '0);
   assign env_sum   = RW'(level_ff) + mul_res;
   assign gain_sum  = (tgt_ff ? RW'(UNITY_GAIN) : '0) + mul_res;

   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_ENV_MUL: begin
            mul_en = 1'b1;
            if (CMP_W'(level_ff) > CMP_W'(thr_ff)) begin
               mul_a = AW'(env_diff);
               mul_b = signed'({2'b00, attack_ff});
            end else begin
               mul_a = AW'(signed'({1'b0, env_cur}));
               mul_b = signed'({2'b00, release_ff});
            end
         end
         S_GAIN_MUL: begin
            mul_en = 1'b1;
            mul_a  = AW'(gain_diff);
            mul_b  = signed'({2'b00, smooth_ff});
         end
         S_OUT_MUL: begin
            mul_en = 1'b1;
            mul_a  = AW'(samp_ff);
            mul_b  = signed'({1'b0, gain_ff});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (accept) state_in = S_ENV_MUL;
         S_ENV_MUL:  state_in = S_ENV_ADD;
         S_ENV_ADD:  state_in = S_GAIN_MUL;
         S_GAIN_MUL: state_in = S_GAIN_ADD;
         S_GAIN_ADD: state_in = S_OUT_MUL;
         S_OUT_MUL:  state_in = S_DONE;
         S_DONE:     if (load_rsp) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      enable_in  = enable_ff;
      thr_in     = thr_ff;
      attack_in  = attack_ff;
      release_in = release_ff;
      smooth_in  = smooth_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_GATE_ENABLE:   enable_in  = csr_wdata[0];
            CSR_THRESHOLD:     thr_in     = csr_wdata[THR_W-1:0];
            CSR_ATTACK_COEFF:  attack_in  = csr_wdata[COEF_W-1:0];
            CSR_RELEASE_COEFF: release_in = csr_wdata[COEF_W-1:0];
            CSR_SMOOTH_COEFF:  smooth_in  = csr_wdata[COEF_W-1:0];
            default:           enable_in  = enable_ff;
         endcase
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      oor_in   = oor_ff;
      act_in   = act_ff;
      ch0_in   = ch0_ff;
      samp_in  = samp_ff;
      level_in = level_ff;
      atk_in   = atk_ff;
      tgt_in   = tgt_ff;
      env_in   = env_ff;
      gain_in  = gain_ff;
      vld_in   = vld_ff;
      if (accept) begin
         idx_in   = rd_addr;
         oor_in   = req_oor;
         act_in   = enable_ff && !req_oor;
         ch0_in   = (req_channel == '0);
         samp_in  = req_sample_in;
         level_in = req_level;
      end
      case (state_ff)
         S_ENV_MUL: begin
            atk_in  = (CMP_W'(level_ff) > CMP_W'(thr_ff));
            gain_in = gain_rd;
         end
         S_ENV_ADD: begin
            env_in = atk_ff ? env_sum[SB-1:0] : mul_res[SB-1:0];
         end
         S_GAIN_MUL: begin
            tgt_in = tgt_now;
         end
         S_GAIN_ADD: begin
            if (act_ff) begin
               gain_in = gain_sum[GAIN_W-1:0];
               vld_in[idx_ff] = 1'b1;
            end
         end
         default: begin
            atk_in = atk_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_gain_in    = rsp_gain_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_lvl_vld_in = rsp_lvl_vld_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = act_ff ? mul_res[SB-1:0] : samp_ff;
         rsp_gain_in    = gain_ff;
         rsp_level_in   = level_ff;
         rsp_lvl_vld_in = act_ff && ch0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         ent_vld_ff <= vld_ff[rd_addr];
      end
      if (wr_en) begin
         mem[idx_ff] <= {env_ff, gain_sum[GAIN_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         thr_ff       <= THRESHOLD_RST;
         attack_ff    <= ATTACK_RST;
         release_ff   <= RELEASE_RST;
         smooth_ff    <= SMOOTH_RST;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         thr_ff       <= thr_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         smooth_ff    <= smooth_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      oor_ff         <= oor_in;
      act_ff         <= act_in;
      ch0_ff         <= ch0_in;
      samp_ff        <= samp_in;
      level_ff       <= level_in;
      atk_ff         <= atk_in;
      tgt_ff         <= tgt_in;
      env_ff         <= env_in;
      gain_ff        <= gain_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_gain_ff    <= rsp_gain_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_lvl_vld_ff <= rsp_lvl_vld_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_gate_gain   = rsp_gain_ff;
   assign rsp_input_level = rsp_level_ff;
   assign rsp_level_valid = rsp_lvl_vld_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_ENV_MUL))
      else $error("accepted item did not start processing");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == S_DONE && $stable(rsp_sample_out) && $stable(rsp_gate_gain)))
      else $error("pending result was overwritten");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gate_gain <= UNITY_GAIN))
      else $error("gain above unity");

endmodule
